FILE: rtl/core/ftbt_pkg.sv
// ----------------------------------------------------------------------------
// ftbt_pkg
// Shared types and constants for the fixed-point to balanced ternary
// converter: controller states, pointer commands and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package ftbt_pkg;

    // Default geometry
    localparam int INT_BITS_DEF       = 16;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int INT_TRITS_DEF      = 12;
    localparam int MAX_FRAC_TRITS_DEF = 32;

    // Fraction trit count register
    localparam int               CFG_W           = 6;
    localparam logic [CFG_W-1:0] FRAC_TRITS_RST  = 6'd32;

    // Reciprocal of three: floor(x / 3) = (x * RECIP3) >> 33 for any x < 2^32
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INT_GEN,
        ST_FRAC_GEN,
        ST_CARRY_PREP,
        ST_CARRY,
        ST_EMIT_PREP,
        ST_EMIT
    } ftbt_state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC,
        PTR_LOAD_INT,
        PTR_LOAD_FRAC,
        PTR_LOAD_TOP,
        PTR_ZERO
    } ftbt_ptr_op_t;

    typedef struct packed {
        ftbt_ptr_op_t ptr_op;
        logic         load_in;
        logic         wr_int;
        logic         wr_frac;
        logic         wr_carry;
        logic         carry_clr;
        logic         emit_load;
    } ftbt_cmd_t;

    typedef struct packed {
        logic ptr_zero;
        logic ptr_at_last;
        logic nfrac_zero;
        logic out_free;
    } ftbt_status_t;

endpackage

FILE: rtl/core/fixed_to_balanced_ternary.sv
// ----------------------------------------------------------------------------
// fixed_to_balanced_ternary
// Converts a signed fixed-point number into balanced ternary trits, integer
// trits most significant first, then the fraction trits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid / in_stall  value (signed, INT_BITS+FRAC_BITS)
//  output    out        out_valid/out_stall  trit, is_fraction, last
//  config    in         cfg_write            cfg_data (fraction trit count)
//
// Each request walks the trit store three times: once to generate ordinary
// digits, once for the carry pass and once to emit. A new request is accepted
// only once the final trit of the previous one is in the output register.
// Reset is asynchronous and active low; the fraction trit count resets to 32.
// Output stalls hold the emit walk; the final trit may sit in the output
// register while the next request is already being converted.
//
module fixed_to_balanced_ternary #(
    parameter int INT_BITS       = ftbt_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS      = ftbt_pkg::FRAC_BITS_DEF,
    parameter int INT_TRITS      = ftbt_pkg::INT_TRITS_DEF,
    parameter int MAX_FRAC_TRITS = ftbt_pkg::MAX_FRAC_TRITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write,
    input  logic [ftbt_pkg::CFG_W-1:0]           cfg_data,
    // input requests
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [INT_BITS+FRAC_BITS-1:0] value,
    // output trits
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [1:0]                    trit,
    output logic                                 is_fraction,
    output logic                                 last
);

    ftbt_pkg::ftbt_cmd_t    cmd;
    ftbt_pkg::ftbt_status_t status;

    // Sequencer: accept, generate, carry, emit
    ftbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Digit units, trit store and output register
    ftbt_datapath #(
        .INT_BITS       (INT_BITS),
        .FRAC_BITS      (FRAC_BITS),
        .INT_TRITS      (INT_TRITS),
        .MAX_FRAC_TRITS (MAX_FRAC_TRITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .trit        (trit),
        .is_fraction (is_fraction),
        .last        (last),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: rtl/core/ftbt_ctrl.sv
// ----------------------------------------------------------------------------
// ftbt_ctrl
// Sequencer: walks the trit store through digit generation, the carry pass
// and emission, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module ftbt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ftbt_pkg::ftbt_status_t status,
    output ftbt_pkg::ftbt_cmd_t    cmd
);

    ftbt_pkg::ftbt_state_t state_reg;
    ftbt_pkg::ftbt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ftbt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ftbt_pkg::ST_INT_GEN;
                end
            end
            ftbt_pkg::ST_INT_GEN:
            begin
                if (status.ptr_zero)
                begin
                    state_next = status.nfrac_zero ? ftbt_pkg::ST_CARRY_PREP
                                                   : ftbt_pkg::ST_FRAC_GEN;
                end
            end
            ftbt_pkg::ST_FRAC_GEN:
            begin
                if (status.ptr_at_last)
                begin
                    state_next = ftbt_pkg::ST_CARRY_PREP;
                end
            end
            ftbt_pkg::ST_CARRY_PREP:
            begin
                state_next = ftbt_pkg::ST_CARRY;
            end
            ftbt_pkg::ST_CARRY:
            begin
                if (status.ptr_zero)
                begin
                    state_next = ftbt_pkg::ST_EMIT_PREP;
                end
            end
            ftbt_pkg::ST_EMIT_PREP:
            begin
                state_next = ftbt_pkg::ST_EMIT;
            end
            ftbt_pkg::ST_EMIT:
            begin
                if (status.out_free && status.ptr_at_last)
                begin
                    state_next = ftbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftbt_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.ptr_op   = ftbt_pkg::PTR_HOLD;
        in_stall     = 1'b1;
        case (state_reg)
            ftbt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.ptr_op  = ftbt_pkg::PTR_LOAD_INT;
                end
            end
            ftbt_pkg::ST_INT_GEN:
            begin
                cmd.wr_int = 1'b1;
                if (status.ptr_zero)
                begin
                    cmd.ptr_op = status.nfrac_zero ? ftbt_pkg::PTR_LOAD_TOP
                                                   : ftbt_pkg::PTR_LOAD_FRAC;
                end
                else
                begin
                    cmd.ptr_op = ftbt_pkg::PTR_DEC;
                end
            end
            ftbt_pkg::ST_FRAC_GEN:
            begin
                cmd.wr_frac = 1'b1;
                cmd.ptr_op  = status.ptr_at_last ? ftbt_pkg::PTR_HOLD : ftbt_pkg::PTR_INC;
            end
            ftbt_pkg::ST_CARRY_PREP:
            begin
                cmd.carry_clr = 1'b1;
            end
            ftbt_pkg::ST_CARRY:
            begin
                cmd.wr_carry = 1'b1;
                cmd.ptr_op   = status.ptr_zero ? ftbt_pkg::PTR_HOLD : ftbt_pkg::PTR_DEC;
            end
            ftbt_pkg::ST_EMIT_PREP:
            begin
                cmd.ptr_op = ftbt_pkg::PTR_HOLD;
            end
            ftbt_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.ptr_op    = status.ptr_at_last ? ftbt_pkg::PTR_ZERO
                                                       : ftbt_pkg::PTR_INC;
                end
            end
            default:
            begin
                cmd.ptr_op = ftbt_pkg::PTR_HOLD;
            end
        endcase
    end

endmodule

FILE: rtl/core/ftbt_datapath.sv
// ----------------------------------------------------------------------------
// ftbt_datapath
// Magnitude split, divide-by-three and times-three digit units, carry unit,
// trit store with registered read, and the output register.
// ----------------------------------------------------------------------------
module ftbt_datapath #(
    parameter int INT_BITS       = ftbt_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS      = ftbt_pkg::FRAC_BITS_DEF,
    parameter int INT_TRITS      = ftbt_pkg::INT_TRITS_DEF,
    parameter int MAX_FRAC_TRITS = ftbt_pkg::MAX_FRAC_TRITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ftbt_pkg::CFG_W-1:0]        cfg_data,
    input  logic signed [INT_BITS+FRAC_BITS-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [1:0]                 trit,
    output logic                              is_fraction,
    output logic                              last,
    input  ftbt_pkg::ftbt_cmd_t               cmd,
    output ftbt_pkg::ftbt_status_t            status
);

    localparam int TOTAL_BITS = INT_BITS + FRAC_BITS;
    localparam int FRAC_W     = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int MAX_TRITS  = INT_TRITS + MAX_FRAC_TRITS;
    localparam int PTR_W      = $clog2(MAX_TRITS);
    localparam int CW         = ftbt_pkg::CFG_W;

    localparam logic [TOTAL_BITS-1:0] FMASK     = (TOTAL_BITS'(1) << FRAC_BITS) - 1'b1;
    localparam logic [CW-1:0]         MAX_FRAC  = CW'(MAX_FRAC_TRITS);
    localparam logic [PTR_W-1:0]      INT_LAST  = PTR_W'(INT_TRITS - 1);
    localparam logic [PTR_W-1:0]      FRAC_BASE = PTR_W'(INT_TRITS);

    logic [CW-1:0]         frac_trits_reg;
    logic [INT_BITS-1:0]   ipart_reg;
    logic [INT_BITS-1:0]   ipart_next;
    logic [FRAC_W-1:0]     fpart_reg;
    logic [FRAC_W-1:0]     fpart_next;
    logic                  neg_reg;
    logic                  carry_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      ptr_next;
    logic [PTR_W-1:0]      last_idx_reg;
    logic                  nfrac_zero_reg;
    logic [1:0]            rd_data_reg;
    logic                  out_valid_reg;
    logic [1:0]            trit_reg;
    logic                  is_fraction_reg;
    logic                  last_reg;

    logic [1:0]            mem [MAX_TRITS];

    logic [TOTAL_BITS-1:0] mag;
    logic [CW-1:0]         nfrac;
    logic [31:0]           div_x;
    logic [63:0]           div_prod;
    logic [30:0]           div_q;
    logic [31:0]           three_q;
    logic [1:0]            int_digit;
    logic [FRAC_W+1:0]     frac_prod;
    logic [1:0]            frac_digit;
    logic [2:0]            csum;
    logic                  cout;
    logic [1:0]            cdigit;
    logic [1:0]            bal;
    logic [1:0]            wdata;
    logic                  mem_we;

    // Magnitude of the input; the most negative value maps onto 2^(TOTAL_BITS-1)
    assign mag   = value[TOTAL_BITS-1] ? (~value + 1'b1) : value;
    assign nfrac = (frac_trits_reg > MAX_FRAC) ? MAX_FRAC : frac_trits_reg;

    // Integer digit: divide by three through the reciprocal
    assign div_x      = 32'(ipart_reg);
    assign div_prod   = div_x * ftbt_pkg::RECIP3;
    assign div_q      = div_prod[63:33];
    assign three_q    = {div_q, 1'b0} + {1'b0, div_q};
    assign int_digit  = 2'(div_x - three_q);
    assign ipart_next = INT_BITS'(div_q);

    // Fraction digit: times three, integer overflow is the digit
    assign frac_prod  = {2'b00, fpart_reg} + {1'b0, fpart_reg, 1'b0};
    assign frac_digit = frac_prod[FRAC_W+1:FRAC_W];
    assign fpart_next = frac_prod[FRAC_W-1:0];

    // Carry unit: add one with carry, subtract one, negate for negative input
    assign csum   = {1'b0, rd_data_reg} + 3'd1 + {2'b00, carry_reg};
    assign cout   = (csum >= 3'd3);
    assign cdigit = cout ? 2'(csum - 3'd3) : csum[1:0];
    always_comb
    begin
        case (cdigit)
            2'd0:    bal = neg_reg ? 2'b01 : 2'b11;
            2'd2:    bal = neg_reg ? 2'b11 : 2'b01;
            default: bal = 2'b00;
        endcase
    end

    assign mem_we = cmd.wr_int | cmd.wr_frac | cmd.wr_carry;
    always_comb
    begin
        if (cmd.wr_int)
        begin
            wdata = int_digit;
        end
        else if (cmd.wr_frac)
        begin
            wdata = frac_digit;
        end
        else
        begin
            wdata = bal;
        end
    end

    always_comb
    begin
        case (cmd.ptr_op)
            ftbt_pkg::PTR_INC:       ptr_next = ptr_reg + 1'b1;
            ftbt_pkg::PTR_DEC:       ptr_next = ptr_reg - 1'b1;
            ftbt_pkg::PTR_LOAD_INT:  ptr_next = INT_LAST;
            ftbt_pkg::PTR_LOAD_FRAC: ptr_next = FRAC_BASE;
            ftbt_pkg::PTR_LOAD_TOP:  ptr_next = last_idx_reg;
            ftbt_pkg::PTR_ZERO:      ptr_next = '0;
            default:                 ptr_next = ptr_reg;
        endcase
    end

    // Trit store: the read is registered and addressed by the next pointer value
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg] <= wdata;
        end
        rd_data_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_trits_reg <= ftbt_pkg::FRAC_TRITS_RST;
            ptr_reg        <= '0;
            carry_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_idx_reg   <= '0;
            nfrac_zero_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                frac_trits_reg <= cfg_data;
            end
            ptr_reg <= ptr_next;
            if (cmd.load_in)
            begin
                neg_reg        <= value[TOTAL_BITS-1];
                last_idx_reg   <= INT_LAST + PTR_W'(nfrac);
                nfrac_zero_reg <= (nfrac == '0);
            end
            if (cmd.carry_clr)
            begin
                carry_reg <= 1'b0;
            end
            else if (cmd.wr_carry)
            begin
                carry_reg <= cout;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ipart_reg <= INT_BITS'(mag >> FRAC_BITS);
            fpart_reg <= FRAC_W'(mag & FMASK);
        end
        else
        begin
            if (cmd.wr_int)
            begin
                ipart_reg <= ipart_next;
            end
            if (cmd.wr_frac)
            begin
                fpart_reg <= fpart_next;
            end
        end
        if (cmd.emit_load)
        begin
            trit_reg        <= rd_data_reg;
            is_fraction_reg <= (ptr_reg >= FRAC_BASE);
            last_reg        <= (ptr_reg == last_idx_reg);
        end
    end

    assign status.ptr_zero    = (ptr_reg == '0);
    assign status.ptr_at_last = (ptr_reg == last_idx_reg);
    assign status.nfrac_zero  = nfrac_zero_reg;
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign trit        = trit_reg;
    assign is_fraction = is_fraction_reg;
    assign last        = last_reg;

endmodule
